// ----- hdl/eec_pkg.sv -----
// ----------------------------------------------------------------------------
// eec_pkg: shared types and constants for the elastic easing curve
// Holds mode and register codes, the pipeline sideband word, the CORDIC
// arctangent table and the square-root chain used by the 2^-x product.
// ----------------------------------------------------------------------------
package eec_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_MAX        = 24;
   localparam int DIV_STAGES        = 45;   // quotient bits of (m << 29) / P
   localparam int PHASE_SHIFT       = 29;
   localparam int EXP_STAGES        = 15;

   localparam logic [1:0] MODE_IN    = 2'd0;
   localparam logic [1:0] MODE_OUT   = 2'd1;
   localparam logic [1:0] MODE_INOUT = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, runs as in-out

   localparam logic REG_EASE_MODE = 1'b0;
   localparam logic REG_PERIOD    = 1'b1;

   localparam logic [15:0] PERIOD_RESET  = 16'd1229;
   localparam logic [15:0] PERIOD_INOUT  = 16'd1843;
   localparam logic [15:0] TIME_ONE      = 16'd32768;
   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

   typedef struct packed {
      logic        pass;       // endpoint or invalid period: value is pass_val
      logic [15:0] pass_val;
      logic        invalid;
      logic        neg;        // sign of shifted time
      logic        neg_term;
      logic        halve;
      logic        add_one;
      logic [15:0] m;          // |shifted time| in Q.15
      logic [3:0]  n;          // integer part of 10*m
      logic [14:0] f;          // fraction of 10*m
      logic [30:0] r;          // 2^-f product, Q1.30
      logic        flip;       // sine folded by a half turn
   } side_type;

   localparam logic [31:0] ATAN_TURNS [CORDIC_MAX] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] x;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      x = v;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // c_1 = sqrt(2^59), c_(k+1) = sqrt(c_k << 30): 2^(-2^-k) in Q1.30
   function automatic logic [30:0] exp_coef(input int k);
      logic [63:0] c;
      c = isqrt64(64'd1 << 59);
      for (int i = 1; i < EXP_STAGES; i++) begin
         if (i < k) begin
            c = isqrt64(c << 30);
         end
      end
      return c[30:0];
   endfunction

endpackage

// ----- hdl/elastic_easing_curve.sv -----
// ----------------------------------------------------------------------------
// elastic_easing_curve: elastic in, out and in-out easing in fixed point
// Q1.15 time in, saturated signed Q2.14 eased value out, through a chain of
// division cells (phase), 2^-x factor cells and CORDIC rotation cells (sine).
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  req     | req_valid, req_ready, req_time_fraction      | word in
//  rsp     | rsp_valid, rsp_ready, rsp_eased_value,       | word out
//          | rsp_invalid_period                           |
//  csr     | csr_wr_en, csr_index, csr_wdata              | register write
//
//  One word enters per cycle while req_ready is high. A word passes one input
//  stage, 45 division cells (one quotient bit each), CORDIC_STAGES rotation
//  cells, the product stage and the output register.
//  Reset clears the valid bits and loads mode 0 and period 1229.
//  The chain up to the product stage advances together; it freezes only when the output
//  register holds an untaken word and the product stage holds another.
// ----------------------------------------------------------------------------
module elastic_easing_curve import eec_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_time_fraction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_eased_value,
   output logic               rsp_invalid_period,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   // configuration registers
   logic [1:0]  mode_ff;
   logic [15:0] period_ff;
   logic [15:0] period_eff;

   // chain control
   logic en;

   // input stage
   logic        vf_ff;
   side_type    front_ff, front_in;
   logic [15:0] t_sat;
   logic [16:0] t2;
   logic [18:0] e10;

   // division chain (index 0 is the input stage)
   logic        dvld [DIV_STAGES+1];
   side_type    dside [DIV_STAGES+1];
   side_type    dside_x [DIV_STAGES];
   logic [15:0] drem [DIV_STAGES+1];
   logic [31:0] dquo [DIV_STAGES+1];

   // CORDIC chain
   logic               cvld [CORDIC_STAGES+1];
   side_type           cside [CORDIC_STAGES+1];
   logic signed [32:0] cx [CORDIC_STAGES+1];
   logic signed [32:0] cy [CORDIC_STAGES+1];
   logic signed [33:0] cz [CORDIC_STAGES+1];
   logic [31:0]        ang;
   logic signed [33:0] zs;

   // product stage
   logic               vm_ff;
   side_type           mside_ff, mside_in;
   logic [62:0]        w_ff, w_in;
   logic signed [32:0] sine;
   logic [31:0]        mag;
   logic [30:0]        amp;
   logic               mneg_in;

   // output stage
   logic               rsp_valid_ff;
   logic signed [15:0] eased_ff, eased_in;
   logic               inval_ff;
   logic [63:0]        wsum;
   logic [16:0]        wq;
   logic signed [18:0] res;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IN;
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_EASE_MODE: mode_ff   <= csr_wdata[1:0];
            REG_PERIOD:    period_ff <= csr_wdata;
            default:       period_ff <= period_ff;
         endcase
      end
   end

   // in-out substitutes 0.45 for a zero period; in and out pass time through
   assign period_eff = (mode_ff[1] && period_ff == '0) ? PERIOD_INOUT : period_ff;

   // advance unless a finished word is stuck behind an untaken output
   assign en        = rsp_ready || !rsp_valid_ff || !vm_ff;
   assign req_ready = en;

   // ---------------------------------------------------------------- input stage
   always_comb begin
      t_sat    = (req_time_fraction > TIME_ONE) ? TIME_ONE : req_time_fraction;
      t2       = {t_sat, 1'b0};
      front_in = '0;
      front_in.pass_val = {1'b0, t_sat[15:1]};
      front_in.r        = 31'd1 << 30;
      if (!mode_ff[1] && period_ff == '0) begin
         front_in.pass    = 1'b1;
         front_in.invalid = 1'b1;
      end else if (t_sat == '0 || t_sat == TIME_ONE) begin
         front_in.pass = 1'b1;
      end
      case (mode_ff)
         MODE_IN: begin
            front_in.m        = TIME_ONE - t_sat;
            front_in.neg      = 1'b1;
            front_in.neg_term = 1'b1;
         end
         MODE_OUT: begin
            front_in.m       = t_sat;
            front_in.add_one = 1'b1;
         end
         default: begin
            front_in.halve = 1'b1;
            if (t2 < {1'b0, TIME_ONE}) begin
               front_in.m        = TIME_ONE - t2[15:0];
               front_in.neg      = 1'b1;
               front_in.neg_term = 1'b1;
            end else begin
               front_in.m       = t2[15:0] - TIME_ONE;
               front_in.add_one = 1'b1;
            end
         end
      endcase
      e10        = {3'd0, front_in.m} * 19'd10;
      front_in.n = e10[18:15];
      front_in.f = e10[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (en) begin
         vf_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   // ---------------------------------------------------------------- division chain
   assign dvld[0]  = vf_ff;
   assign dside[0] = front_ff;
   assign drem[0]  = '0;
   assign dquo[0]  = '0;

   generate
      for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
         // the first cells also carry one 2^-x factor each
         if (j < EXP_STAGES) begin : g_exp
            eec_exp_cell #(.K(j + 1)) u_exp (
               .side_i (dside[j]),
               .side_o (dside_x[j])
            );
         end else begin : g_noexp
            assign dside_x[j] = dside[j];
         end

         eec_div_cell #(.DIV_BIT(DIV_STAGES - 1 - j)) u_div (
            .clock  (clock),
            .reset  (reset),
            .en     (en),
            .period (period_eff),
            .vld_i  (dvld[j]),
            .side_i (dside_x[j]),
            .rem_i  (drem[j]),
            .quo_i  (dquo[j]),
            .vld_o  (dvld[j+1]),
            .side_o (dside[j+1]),
            .rem_o  (drem[j+1]),
            .quo_o  (dquo[j+1])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- angle fold
   // angle = (+-q) - quarter turn; fold into +-1/4 turn, flipping the sine
   always_comb begin
      ang      = (dside[DIV_STAGES].neg ? (32'd0 - dquo[DIV_STAGES]) : dquo[DIV_STAGES])
                 - 32'h4000_0000;
      zs       = {{2{ang[31]}}, ang};
      cside[0] = dside[DIV_STAGES];
      cvld[0]  = dvld[DIV_STAGES];
      cx[0]    = CORDIC_X0;
      cy[0]    = '0;
      cside[0].flip = 1'b0;
      if (zs > 34'sh4000_0000) begin
         cz[0]         = zs - 34'sh8000_0000;
         cside[0].flip = 1'b1;
      end else if (zs < -34'sh4000_0000) begin
         cz[0]         = zs + 34'sh8000_0000;
         cside[0].flip = 1'b1;
      end else begin
         cz[0] = zs;
      end
   end

   // ---------------------------------------------------------------- CORDIC chain
   generate
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
         eec_cordic_cell #(.IDX(i)) u_rot (
            .clock  (clock),
            .reset  (reset),
            .en     (en),
            .vld_i  (cvld[i]),
            .side_i (cside[i]),
            .x_i    (cx[i]),
            .y_i    (cy[i]),
            .z_i    (cz[i]),
            .vld_o  (cvld[i+1]),
            .side_o (cside[i+1]),
            .x_o    (cx[i+1]),
            .y_o    (cy[i+1]),
            .z_o    (cz[i+1])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- product stage
   always_comb begin
      sine    = cside[CORDIC_STAGES].flip ? -cy[CORDIC_STAGES] : cy[CORDIC_STAGES];
      mag     = sine[32] ? 32'(-sine) : sine[31:0];
      mneg_in = cside[CORDIC_STAGES].neg_term ^ sine[32];
      amp     = cside[CORDIC_STAGES].r >> cside[CORDIC_STAGES].n;
      w_in    = {32'd0, amp} * {31'd0, mag};
      mside_in          = cside[CORDIC_STAGES];
      mside_in.neg_term = mneg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= cvld[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mside_ff <= mside_in;
         w_ff     <= w_in;
      end
   end

   // ---------------------------------------------------------------- output stage
   // round half up on the magnitude, sign, offset, saturate
   always_comb begin
      wsum = {1'b0, w_ff} + (mside_ff.halve ? (64'd1 << 46) : (64'd1 << 45));
      wq   = mside_ff.halve ? wsum[63:47] : wsum[62:46];
      res  = mside_ff.neg_term ? -$signed({2'b00, wq}) : $signed({2'b00, wq});
      if (mside_ff.add_one) begin
         res = res + 19'sd16384;
      end
      if (mside_ff.pass) begin
         eased_in = $signed(mside_ff.pass_val);
      end else if (res > 19'sd32767) begin
         eased_in = 16'sh7FFF;
      end else if (res < -19'sd32768) begin
         eased_in = -16'sh8000;
      end else begin
         eased_in = res[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready || !rsp_valid_ff) begin
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !rsp_valid_ff) begin
         eased_ff <= eased_in;
         inval_ff <= mside_ff.invalid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_eased_value    = eased_ff;
   assign rsp_invalid_period = inval_ff;

endmodule

// ----- hdl/eec_exp_cell.sv -----
// ----------------------------------------------------------------------------
// eec_exp_cell: one factor of the 2^-x product
// Multiply the running product by 2^(-2^-K) when fraction bit K is set.
// ----------------------------------------------------------------------------
module eec_exp_cell import eec_pkg::*; #(
   parameter int K = 1
) (
   input  side_type side_i,
   output side_type side_o
);

   localparam logic [30:0] COEF = exp_coef(K);

   logic [61:0] prod;

   always_comb begin
      prod   = {31'd0, side_i.r} * {31'd0, COEF} + 62'd536870912;
      side_o = side_i;
      if (side_i.f[EXP_STAGES - K]) begin
         side_o.r = prod[60:30];
      end
   end

endmodule

// ----- hdl/eec_div_cell.sv -----
// ----------------------------------------------------------------------------
// eec_div_cell: one restoring division step
// Shift in one dividend bit, subtract the period where it fits, and hand
// remainder, quotient and sideband to the next cell.
// ----------------------------------------------------------------------------
module eec_div_cell import eec_pkg::*; #(
   parameter int DIV_BIT = 44
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [15:0] period,
   input  logic        vld_i,
   input  side_type    side_i,
   input  logic [15:0] rem_i,
   input  logic [31:0] quo_i,
   output logic        vld_o,
   output side_type    side_o,
   output logic [15:0] rem_o,
   output logic [31:0] quo_o
);

   logic        nbit;
   logic [16:0] trial;
   logic        fits;
   logic [16:0] diff;
   logic        vld_ff;
   side_type    side_ff;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;

   generate
      if (DIV_BIT >= PHASE_SHIFT) begin : g_mbit
         assign nbit = side_i.m[DIV_BIT - PHASE_SHIFT];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
   endgenerate

   always_comb begin
      trial  = {rem_i, nbit};
      fits   = trial >= {1'b0, period};
      diff   = trial - {1'b0, period};
      rem_in = fits ? diff[15:0] : trial[15:0];
      quo_in = {quo_i[30:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_i;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign vld_o  = vld_ff;
   assign side_o = side_ff;
   assign rem_o  = rem_ff;
   assign quo_o  = quo_ff;

endmodule

// ----- hdl/eec_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// eec_cordic_cell: one CORDIC micro-rotation
// Rotate (x, y) toward the residual angle and drop its arctangent.
// ----------------------------------------------------------------------------
module eec_cordic_cell import eec_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               vld_i,
   input  side_type           side_i,
   input  logic signed [32:0] x_i,
   input  logic signed [32:0] y_i,
   input  logic signed [33:0] z_i,
   output logic               vld_o,
   output side_type           side_o,
   output logic signed [32:0] x_o,
   output logic signed [32:0] y_o,
   output logic signed [33:0] z_o
);

   localparam logic signed [33:0] ATAN = $signed({2'b00, ATAN_TURNS[IDX]});

   logic               vld_ff;
   side_type           side_ff;
   logic signed [32:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;

   always_comb begin
      if (!z_i[33]) begin
         x_in = x_i - (y_i >>> IDX);
         y_in = y_i + (x_i >>> IDX);
         z_in = z_i - ATAN;
      end else begin
         x_in = x_i + (y_i >>> IDX);
         y_in = y_i - (x_i >>> IDX);
         z_in = z_i + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_i;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign vld_o  = vld_ff;
   assign side_o = side_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;

endmodule
